@@ src/remp_pkg.sv @@
// Shared constants, codes and controller/datapath structs for the enclosed-mass profile block.
package remp_pkg;

  // input word commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_Z  = 2'd2;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CENTER_W   = 31;
  localparam int BWIDTH_W   = 32;
  localparam int MASS_W     = 32;
  localparam int SUM_W      = 48;
  localparam int IDX_W      = 9;
  localparam int SQ_STEPS   = 4;

  typedef struct packed {
    logic capture;
    logic diff;
    logic sq_step;
    logic lim;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic add_rd;
    logic add_wr;
    logic rd_rd;
    logic rd_out;
    logic clr_start;
    logic clr_step;
  } remp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic drop;
    logic out_free;
  } remp_sts_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

@@ src/remp_in_if.sv @@
// Input channel: command word with particle position and mass.
interface remp_in_if #(
  parameter int POS_WIDTH = 31
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic [remp_pkg::MASS_W-1:0] mass;

  modport source(output valid, cmd, pos_x, pos_y, pos_z, mass, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, mass, output ready);
endinterface

@@ src/remp_out_if.sv @@
// Result channel: one cumulative bin word per read command.
interface remp_out_if;
  logic                        valid;
  logic                        ready;
  logic [remp_pkg::IDX_W-1:0]  bin_index;
  logic [remp_pkg::SUM_W-1:0]  enclosed_mass;
  logic                        last;

  modport source(output valid, bin_index, enclosed_mass, last, input ready);
  modport sink(input valid, bin_index, enclosed_mass, last, output ready);
endinterface

@@ src/remp_regs.sv @@
// APB-style configuration registers: profile center and bin width.
module remp_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [remp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [remp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [remp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output logic [remp_pkg::CENTER_W-1:0]   center_x,
  output logic [remp_pkg::CENTER_W-1:0]   center_y,
  output logic [remp_pkg::CENTER_W-1:0]   center_z,
  output logic [remp_pkg::BWIDTH_W-1:0]   bin_width
);

  logic [remp_pkg::CENTER_W-1:0] cx_r, cx_nxt;
  logic [remp_pkg::CENTER_W-1:0] cy_r, cy_nxt;
  logic [remp_pkg::CENTER_W-1:0] cz_r, cz_nxt;
  logic [remp_pkg::BWIDTH_W-1:0] bw_r, bw_nxt;
  logic [1:0]                    idx;
  logic                          wr;

  assign idx        = cfg_paddr[3:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    bw_nxt = bw_r;
    if (wr) begin
      unique case (idx)
        remp_pkg::REG_CENTER_X:  cx_nxt = cfg_pwdata[remp_pkg::CENTER_W-1:0];
        remp_pkg::REG_CENTER_Y:  cy_nxt = cfg_pwdata[remp_pkg::CENTER_W-1:0];
        remp_pkg::REG_CENTER_Z:  cz_nxt = cfg_pwdata[remp_pkg::CENTER_W-1:0];
        remp_pkg::REG_BIN_WIDTH: bw_nxt = cfg_pwdata[remp_pkg::BWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      remp_pkg::REG_CENTER_X:  cfg_prdata = remp_pkg::CFG_DATA_W'(cx_r);
      remp_pkg::REG_CENTER_Y:  cfg_prdata = remp_pkg::CFG_DATA_W'(cy_r);
      remp_pkg::REG_CENTER_Z:  cfg_prdata = remp_pkg::CFG_DATA_W'(cz_r);
      remp_pkg::REG_BIN_WIDTH: cfg_prdata = remp_pkg::CFG_DATA_W'(bw_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      bw_r <= remp_pkg::BWIDTH_W'(1);
    end else begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      bw_r <= bw_nxt;
    end
  end

  assign center_x  = cx_r;
  assign center_y  = cy_r;
  assign center_z  = cz_r;
  assign bin_width = bw_r;

endmodule

@@ src/remp_ctrl.sv @@
// Sequencer for add, read and clear commands, plus the store clearing sweep.
module remp_ctrl #(
  parameter int NUM_BINS  = 512,
  parameter int POS_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  output logic                  in_ready,
  input  remp_pkg::remp_sts_t   sts_i,
  output remp_pkg::remp_cmd_t   cmd_o
);

  localparam int BW         = $clog2(NUM_BINS);
  localparam int SQRT_STEPS = POS_WIDTH + 1;
  localparam int CW_A       = $clog2(SQRT_STEPS);
  localparam int CW_B       = $clog2(BW + 1);
  localparam int CW         = (CW_A > CW_B) ? CW_A : CW_B;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_LIM   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_AADR  = 4'd8;
  localparam logic [3:0] S_AWR   = 4'd9;
  localparam logic [3:0] S_RADR  = 4'd10;
  localparam logic [3:0] S_ROUT  = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CW'(1);
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          case (in_cmd)
            remp_pkg::CMD_ADD:   state_nxt = S_DIFF;
            remp_pkg::CMD_READ:  state_nxt = S_RADR;
            remp_pkg::CMD_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_nxt       = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_r == CW'(remp_pkg::SQ_STEPS - 1)) state_nxt = S_LIM;
      end
      S_LIM: begin
        cmd_o.lim = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_r == CW'(SQRT_STEPS - 1)) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_r == CW'(BW - 1)) state_nxt = sts_i.drop ? S_IDLE : S_AADR;
      end
      S_AADR: begin
        cmd_o.add_rd = 1'b1;
        state_nxt    = S_AWR;
      end
      S_AWR: begin
        cmd_o.add_wr = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RADR: begin
        if (sts_i.out_free) begin
          cmd_o.rd_rd = 1'b1;
          state_nxt   = S_ROUT;
        end
      end
      S_ROUT: begin
        cmd_o.rd_out = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a word is only taken while no command is in progress
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cnt_r == '0 || $past(state_r) != S_IDLE || $past(!in_valid)))
    else $error("ready raised with a stale step count");
  a_clr_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> state_r == S_CLR)
    else $error("reset did not start the clearing sweep");
  a_div_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AADR) |-> ($past(state_r) == S_DIV && !sts_i.drop))
    else $error("store update entered without a valid bin");

endmodule

@@ src/remp_dp.sv @@
// Datapath: distance, integer square root, bin divide, bin store and cumulative readout.
module remp_dp #(
  parameter int NUM_BINS  = 512,
  parameter int POS_WIDTH = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  remp_pkg::remp_cmd_t             cmd_i,
  output remp_pkg::remp_sts_t             sts_o,
  input  logic signed [POS_WIDTH-1:0]     pos_x,
  input  logic signed [POS_WIDTH-1:0]     pos_y,
  input  logic signed [POS_WIDTH-1:0]     pos_z,
  input  logic [remp_pkg::MASS_W-1:0]     mass,
  input  logic [remp_pkg::CENTER_W-1:0]   center_x,
  input  logic [remp_pkg::CENTER_W-1:0]   center_y,
  input  logic [remp_pkg::CENTER_W-1:0]   center_z,
  input  logic [remp_pkg::BWIDTH_W-1:0]   bin_width,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [remp_pkg::IDX_W-1:0]      out_bin_index,
  output logic [remp_pkg::SUM_W-1:0]      out_enclosed_mass,
  output logic                            out_last
);

  localparam int BW  = $clog2(NUM_BINS);
  localparam int PW2 = 2 * POS_WIDTH;
  localparam int AW  = PW2 + 2;
  localparam int RW  = POS_WIDTH + 1;
  localparam int LW  = remp_pkg::BWIDTH_W + BW;
  localparam int SW  = remp_pkg::SUM_W;

  function automatic logic [POS_WIDTH-1:0] abs_diff(input logic [POS_WIDTH-1:0] a,
                                                    input logic [POS_WIDTH-1:0] b);
    logic signed [POS_WIDTH:0] d;
    d = $signed({a[POS_WIDTH-1], a}) - $signed({b[POS_WIDTH-1], b});
    return d[POS_WIDTH] ? POS_WIDTH'(-d) : d[POS_WIDTH-1:0];
  endfunction

  logic [POS_WIDTH-1:0]      px_r, py_r, pz_r;
  logic [remp_pkg::MASS_W-1:0] mass_r;
  logic [POS_WIDTH-1:0]      d0_r, d1_r, d2_r;
  logic [PW2-1:0]            prod_r;
  logic [AW-1:0]             acc_r;
  logic [AW-1:0]             x_r, res_r, bit_r, trial;
  logic [remp_pkg::BWIDTH_W-1:0] w_r, w_eff;
  logic [LW-1:0]             lim_r, dvs_r;
  logic                      drop_r;
  logic [RW-1:0]             rem_r;
  logic                      ge;
  logic [BW-1:0]             q_r, bin;
  logic [SW-1:0]             mem [NUM_BINS];
  logic [SW-1:0]             rdata_r, wdata, rd_sum;
  logic [BW-1:0]             raddr, waddr;
  logic                      we;
  logic [BW-1:0]             ptr_r, clr_addr_r;
  logic [SW-1:0]             run_r;
  logic                      rd_last, clr_last;
  logic                      out_vld_r;
  logic [remp_pkg::IDX_W-1:0] out_idx_r;
  logic [SW-1:0]             out_mass_r;
  logic                      out_last_r;

  assign w_eff    = (bin_width == '0) ? remp_pkg::BWIDTH_W'(1) : bin_width;
  assign trial    = res_r + bit_r;
  assign ge       = LW'(rem_r) >= dvs_r;
  assign bin      = q_r + BW'(1);
  assign rd_last  = ptr_r == BW'(NUM_BINS - 1);
  assign clr_last = clr_addr_r == BW'(NUM_BINS - 1);
  assign rd_sum   = remp_pkg::sat_add(run_r, rdata_r);

  // distance squared, root and quotient
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      mass_r <= mass;
    end
    if (cmd_i.diff) begin
      d0_r   <= abs_diff(px_r, center_x[POS_WIDTH-1:0]);
      d1_r   <= abs_diff(py_r, center_y[POS_WIDTH-1:0]);
      d2_r   <= abs_diff(pz_r, center_z[POS_WIDTH-1:0]);
      prod_r <= '0;
      acc_r  <= '0;
    end
    // one square per step; sum lags the multiplier by one step
    if (cmd_i.sq_step) begin
      prod_r <= PW2'(d0_r) * PW2'(d0_r);
      d0_r   <= d1_r;
      d1_r   <= d2_r;
      d2_r   <= '0;
      acc_r  <= acc_r + AW'(prod_r);
    end
    if (cmd_i.lim) begin
      x_r   <= acc_r;
      res_r <= '0;
      bit_r <= {2'b01, {(AW - 2){1'b0}}};
      w_r   <= w_eff;
      lim_r <= LW'(w_eff) * LW'(NUM_BINS - 1);
    end
    if (cmd_i.sqrt_step) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd_i.div_init) begin
      drop_r <= LW'(res_r[RW-1:0]) >= lim_r;
      rem_r  <= res_r[RW-1:0];
      dvs_r  <= LW'(w_r) << (BW - 1);
      q_r    <= '0;
    end
    // quotient is known to fit BW bits once the range check passes
    if (cmd_i.div_step) begin
      if (ge) rem_r <= rem_r - RW'(dvs_r);
      q_r   <= (q_r << 1) | BW'(ge);
      dvs_r <= dvs_r >> 1;
    end
  end

  // bin store
  assign raddr = cmd_i.add_rd ? bin : ptr_r;
  assign waddr = cmd_i.clr_step ? clr_addr_r : bin;
  assign we    = cmd_i.clr_step | cmd_i.add_wr;
  assign wdata = cmd_i.clr_step ? '0 : remp_pkg::sat_add(rdata_r, SW'(mass_r));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_out) begin
      out_idx_r  <= remp_pkg::IDX_W'(ptr_r);
      out_mass_r <= rd_sum;
      out_last_r <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      run_r      <= '0;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        ptr_r      <= '0;
        run_r      <= '0;
        clr_addr_r <= '0;
      end else if (cmd_i.clr_step) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + BW'(1);
      end
      if (cmd_i.rd_out) begin
        ptr_r <= rd_last ? '0 : ptr_r + BW'(1);
        run_r <= rd_last ? '0 : rd_sum;
      end
      if (cmd_i.rd_out) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  assign sts_o.clr_last = clr_last;
  assign sts_o.drop     = drop_r;
  assign sts_o.out_free = !out_vld_r || out_ready;

  assign out_valid         = out_vld_r;
  assign out_bin_index     = out_idx_r;
  assign out_enclosed_mass = out_mass_r;
  assign out_last          = out_last_r;

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(cmd_i.rd_out))
    else $error("result word appeared without a read");
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.rd_out |-> !out_vld_r)
    else $error("result register overwritten before it was taken");
  a_no_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.add_wr |-> bin != '0)
    else $error("particle mass written to bin zero");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ptr_r) < NUM_BINS) && (32'(clr_addr_r) < NUM_BINS))
    else $error("bin pointer beyond the store");

endmodule

@@ src/radial_enclosed_mass_profile.sv @@
// Top level: enclosed-mass radial profile with APB configuration.
// Add word: the next word is taken only once the update finishes; root and divide each
//   resolve one bit per cycle, and a dropped particle skips the store update.
// Read word: S_RADR waits for a free result register, S_ROUT loads it, then the next word is taken.
// Clear word: one bin zeroed per cycle through the single write port, then back to idle.
// Reset: synchronous active low; a clearing sweep of all NUM_BINS bins runs before the first word.
module radial_enclosed_mass_profile #(
  parameter int NUM_BINS  = 512,
  parameter int POS_WIDTH = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  remp_in_if.sink                         in_ch,
  remp_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [remp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [remp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [remp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic [remp_pkg::CENTER_W-1:0] center_x, center_y, center_z;
  logic [remp_pkg::BWIDTH_W-1:0] bin_width;
  remp_pkg::remp_cmd_t           cmd;
  remp_pkg::remp_sts_t           sts;

  remp_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .bin_width  (bin_width)
  );

  remp_ctrl #(
    .NUM_BINS (NUM_BINS),
    .POS_WIDTH(POS_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_cmd  (in_ch.cmd),
    .in_ready(in_ch.ready),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  remp_dp #(
    .NUM_BINS (NUM_BINS),
    .POS_WIDTH(POS_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pos_x            (in_ch.pos_x),
    .pos_y            (in_ch.pos_y),
    .pos_z            (in_ch.pos_z),
    .mass             (in_ch.mass),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_z         (center_z),
    .bin_width        (bin_width),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_bin_index    (out_ch.bin_index),
    .out_enclosed_mass(out_ch.enclosed_mass),
    .out_last         (out_ch.last)
  );

endmodule
